// ----- rtl/ptps2_pkg.sv -----
package ptps2_pkg;

  typedef enum logic [1:0] {
    OP_PS2_BYTE = 2'd0,
    OP_ABS      = 2'd1,
    OP_REL      = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_SUPPRESS = 2'd2;

  localparam logic [7:0] SYNC_BIT      = 8'h08;
  localparam logic [7:0] OVERFLOW_BITS = 8'hC0;
  localparam int         ACCEL_SLOW    = 3;
  localparam int         ACCEL_MID     = 10;

  // Classified command passed from front to back.
  typedef struct packed {
    op_t          kind;     // OP_PS2_BYTE here means a complete, accepted PS/2 report
    logic [31:0]  ax;
    logic [31:0]  ay;
    logic [31:0]  lox;
    logic [31:0]  hix;
    logic [31:0]  loy;
    logic [31:0]  hiy;
    logic [17:0]  dx;       // accelerated motion, screen sense
    logic [17:0]  dy;
    logic         btn;
  } cmd_t;

  // Acceleration on a signed 16-bit motion value; result fits in 18 bits.
  function automatic logic [17:0] speed_up(input logic signed [15:0] d);
    logic signed [17:0] e;
    logic [15:0]        mag;
    begin
      e   = 18'(d);
      mag = d[15] ? 16'(-d) : 16'(d);
      if (mag <= 16'(ACCEL_SLOW))
        speed_up = e;
      else if (mag <= 16'(ACCEL_MID))
        speed_up = 18'(e * 2);
      else
        speed_up = 18'(e * 3);
    end
  endfunction

endpackage

// ----- rtl/ptps2_front.sv -----
module ptps2_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 suppress,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_ps2_byte,
  input  logic [31:0]          in_abs_x,
  input  logic [31:0]          in_abs_y,
  input  logic [31:0]          in_range_min_x,
  input  logic [31:0]          in_range_max_x,
  input  logic [31:0]          in_range_min_y,
  input  logic [31:0]          in_range_max_y,
  input  logic signed [15:0]   in_rel_dx,
  input  logic signed [15:0]   in_rel_dy,
  input  logic                 in_left_button,
  output logic                 q_push,
  output ptps2_pkg::cmd_t      q_data,
  input  logic                 q_full
);

  logic [7:0] pkt0_r, pkt1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  logic signed [15:0] pdx, pdy;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // 9-bit sign extension of the report bytes
  assign pdx = {{8{pkt0_r[4]}}, pkt1_r};
  assign pdy = {{8{pkt0_r[5]}}, in_ps2_byte};

  always_comb begin
    cnt_nxt = cnt_r;
    q_push  = 1'b0;
    q_data  = '0;
    q_data.ax  = in_abs_x;
    q_data.ay  = in_abs_y;
    q_data.lox = in_range_min_x;
    q_data.hix = in_range_max_x;
    q_data.loy = in_range_min_y;
    q_data.hiy = in_range_max_y;
    q_data.btn = in_left_button;
    q_data.kind = ptps2_pkg::op_t'(in_op);
    case (ptps2_pkg::op_t'(in_op))
      ptps2_pkg::OP_PS2_BYTE: begin
        if (acc) begin
          if (cnt_r == 2'd0) begin
            if ((in_ps2_byte & ptps2_pkg::SYNC_BIT) != 8'd0) cnt_nxt = 2'd1;
          end else if (cnt_r == 2'd1) begin
            cnt_nxt = 2'd2;
          end else begin
            cnt_nxt = 2'd0;
            q_push  = !suppress && ((pkt0_r & ptps2_pkg::OVERFLOW_BITS) == 8'd0);
          end
        end
        q_data.dx  = ptps2_pkg::speed_up(pdx);
        q_data.dy  = 18'(-ptps2_pkg::speed_up(pdy));
        q_data.btn = pkt0_r[0];
      end
      ptps2_pkg::OP_REL: begin
        q_push    = acc;
        q_data.dx = ptps2_pkg::speed_up(in_rel_dx);
        q_data.dy = ptps2_pkg::speed_up(in_rel_dy);
      end
      default: q_push = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (acc && in_op == 2'(ptps2_pkg::OP_PS2_BYTE)) begin
      if (cnt_r == 2'd0) pkt0_r <= in_ps2_byte;
      if (cnt_r == 2'd1) pkt1_r <= in_ps2_byte;
    end
  end

endmodule

// ----- rtl/ptps2_fifo.sv -----
module ptps2_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptps2_pkg::cmd_t wdata,
  output logic            full,
  output logic            nempty,
  input  logic            pop,
  output ptps2_pkg::cmd_t rdata
);

  ptps2_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign nempty = cnt_r != 2'd0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- rtl/ptps2_div.sv -----
module ptps2_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [47:0] quo
);

  logic [47:0] q_r;
  logic [32:0] d_r;
  logic [33:0] rem_r;
  logic [5:0]  n_r;
  logic        busy_r;
  logic [33:0] sh;
  logic [34:0] diff;

  assign sh   = {rem_r[32:0], q_r[47]};
  assign diff = {1'b0, sh} - {2'b0, d_r};
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= 6'd48;
      end else if (busy_r) begin
        n_r <= n_r - 6'd1;
        if (n_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[34]) begin
        rem_r <= diff[33:0];
        q_r   <= {q_r[46:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[46:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/ptps2_back.sv -----
module ptps2_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [15:0]     width,
  input  logic [15:0]     height,
  input  logic            q_nempty,
  input  ptps2_pkg::cmd_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_pointer_x_out,
  output logic [15:0]     out_pointer_y_out,
  output logic            out_button_down,
  output logic            out_clicked,
  output logic            out_changed
);

  typedef enum logic [2:0] {S_IDLE, S_DIVX, S_WAITX, S_DIVY, S_WAITY} st_t;

  st_t         st_r;
  logic [15:0] px_r, py_r, rx_r, ry_r;
  logic        held_r, click_r, fresh_r, rdown_r;
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic [32:0] div_den;
  logic        selx;
  logic [31:0] v, lo, hi;
  logic [15:0] lim;
  logic [15:0] dir_val, nx, ny, cx, cy, mapq;
  logic        chg;
  logic        ovalid_r;
  logic        rd_pop;

  ptps2_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quo(div_quo)
  );

  function automatic logic [15:0] clamp(input logic signed [18:0] s, input logic [15:0] l);
    if (s < 0 || l == 16'd0) clamp = 16'd0;
    else if (s >= $signed({3'b0, l})) clamp = l - 16'd1;
    else clamp = s[15:0];
  endfunction

  function automatic logic [15:0] clampu(input logic [47:0] s, input logic [15:0] l);
    if (l == 16'd0) clampu = 16'd0;
    else if (s >= {32'd0, l}) clampu = l - 16'd1;
    else clampu = s[15:0];
  endfunction

  assign selx = (st_r == S_DIVX) || (st_r == S_WAITX) || (st_r == S_IDLE);
  assign v    = selx ? q_data.ax  : q_data.ay;
  assign lo   = selx ? q_data.lox : q_data.loy;
  assign hi   = selx ? q_data.hix : q_data.hiy;
  assign lim  = selx ? width : height;
  assign dir_val = clampu({16'd0, v}, lim);
  assign div_num = 48'((v < lo ? 32'd0 : v - lo) * lim);
  assign div_den = {1'b0, hi} - {1'b0, lo} + 33'd1;
  assign div_start = (st_r == S_DIVX || st_r == S_DIVY) && hi > lo;
  assign mapq = clampu(div_quo, lim);

  assign nx = clamp(19'($signed({3'b0, px_r})) + 19'($signed(q_data.dx)), width);
  assign ny = clamp(19'($signed({3'b0, py_r})) + 19'($signed(q_data.dy)), height);
  assign cx = clamp(19'(fresh_r ? {4'b0, width[15:1]} : {3'b0, px_r}), width);
  assign cy = clamp(19'(fresh_r ? {4'b0, height[15:1]} : {3'b0, py_r}), height);
  assign chg = fresh_r || cx != rx_r || cy != ry_r || held_r != rdown_r;

  assign out_valid = ovalid_r;
  assign q_pop = q_nempty && (
    (st_r == S_IDLE && q_data.kind != ptps2_pkg::OP_ABS &&
     !(q_data.kind == ptps2_pkg::OP_READ && ovalid_r && out_stall)) ||
    (st_r == S_DIVY && !(hi > lo)) || (st_r == S_WAITY && div_done));
  assign rd_pop = st_r == S_IDLE && q_pop && q_data.kind == ptps2_pkg::OP_READ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      px_r     <= '0;
      py_r     <= '0;
      rx_r     <= '0;
      ry_r     <= '0;
      held_r   <= 1'b0;
      click_r  <= 1'b0;
      fresh_r  <= 1'b1;
      rdown_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall && !rd_pop) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_nempty) begin
            case (q_data.kind)
              ptps2_pkg::OP_ABS: st_r <= S_DIVX;
              ptps2_pkg::OP_READ: begin
                if (q_pop) begin
                  px_r <= cx; py_r <= cy; rx_r <= cx; ry_r <= cy;
                  rdown_r <= held_r; fresh_r <= 1'b0; click_r <= 1'b0;
                  ovalid_r <= 1'b1;
                  out_pointer_x_out <= cx;
                  out_pointer_y_out <= cy;
                  out_button_down   <= held_r;
                  out_clicked       <= click_r;
                  out_changed       <= chg;
                end
              end
              default: begin
                px_r <= nx; py_r <= ny;
                if (q_data.btn && !held_r) click_r <= 1'b1;
                held_r <= q_data.btn;
              end
            endcase
          end
        end
        S_DIVX: begin
          if (hi > lo) st_r <= S_WAITX;
          else begin px_r <= dir_val; st_r <= S_DIVY; end
        end
        S_WAITX: if (div_done) begin px_r <= mapq; st_r <= S_DIVY; end
        S_DIVY: begin
          if (hi > lo) st_r <= S_WAITY;
          else begin
            py_r <= dir_val; st_r <= S_IDLE;
            if (q_data.btn && !held_r) click_r <= 1'b1;
            held_r <= q_data.btn;
          end
        end
        S_WAITY: if (div_done) begin
          py_r <= mapq; st_r <= S_IDLE;
          if (q_data.btn && !held_r) click_r <= 1'b1;
          held_r <= q_data.btn;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pointer_tracker_ps2_absolute.sv -----
// Reads: a read transaction's report is registered when the back end takes it
//   from the queue. Absolute: a transaction holds the back end for two 48-step
//   divisions, skipping each axis whose device range max is not above its min.
// Throughput: one transaction a cycle except behind an absolute report or while a stalled output holds back a read.
// Reset (rst_n, synchronous, active low) restores screen 640x480, clears
//   position, buttons and framing and marks the pointer fresh.
module pointer_tracker_ps2_absolute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_ps2_byte,
  input  logic [31:0]        in_abs_x,
  input  logic [31:0]        in_abs_y,
  input  logic [31:0]        in_range_min_x,
  input  logic [31:0]        in_range_max_x,
  input  logic [31:0]        in_range_min_y,
  input  logic [31:0]        in_range_max_y,
  input  logic signed [15:0] in_rel_dx,
  input  logic signed [15:0] in_rel_dy,
  input  logic               in_left_button,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pointer_x_out,
  output logic [15:0]        out_pointer_y_out,
  output logic               out_button_down,
  output logic               out_clicked,
  output logic               out_changed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] width_r, height_r;
  logic        suppress_r;
  logic        q_push, q_full, q_nempty, q_pop;
  ptps2_pkg::cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indices are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 16'd640;
      height_r   <= 16'd480;
      suppress_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptps2_pkg::REG_WIDTH:    width_r    <= cfg_data;
        ptps2_pkg::REG_HEIGHT:   height_r   <= cfg_data;
        ptps2_pkg::REG_SUPPRESS: suppress_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: framing, filtering and acceleration
  ptps2_front u_front (
    .clk(clk), .rst_n(rst_n), .suppress(suppress_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_ps2_byte(in_ps2_byte), .in_abs_x(in_abs_x), .in_abs_y(in_abs_y),
    .in_range_min_x(in_range_min_x), .in_range_max_x(in_range_max_x),
    .in_range_min_y(in_range_min_y), .in_range_max_y(in_range_max_y),
    .in_rel_dx(in_rel_dx), .in_rel_dy(in_rel_dy),
    .in_left_button(in_left_button),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  ptps2_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .nempty(q_nempty), .pop(q_pop), .rdata(q_rdata)
  );

  // back: pointer state, absolute scaling and the report register
  ptps2_back u_back (
    .clk(clk), .rst_n(rst_n), .width(width_r), .height(height_r),
    .q_nempty(q_nempty), .q_data(q_rdata), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pointer_x_out(out_pointer_x_out), .out_pointer_y_out(out_pointer_y_out),
    .out_button_down(out_button_down), .out_clicked(out_clicked),
    .out_changed(out_changed)
  );

endmodule
